/* design/assert_macros.svh */
// Assertion shorthands; clk_i and rst_ni come from the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SVFPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SVFPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/svfpt_pkg.sv */
package svfpt_pkg;

  localparam int unsigned FramePeriodDef = 10;
  localparam int unsigned Slots          = 2;
  localparam logic [15:0] AgeCap         = 16'hFFFF;
  localparam logic [31:0] NoFrame        = 32'hFFFF_FFFF;

  localparam logic [3:0]  QueryPhaseRst  = 4'd4;
  localparam logic [15:0] StaleLimitRst  = 16'd250;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgQueryPhase = 2'd0,
    CfgStaleLimit = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [7:0]  servo_id_0;
    logic [7:0]  servo_id_1;
    logic        poll_en;
    logic [31:0] event_sequence;
    logic [7:0]  event_servo_id;
    logic        event_ok;
    logic [15:0] event_position_us;
    logic [31:0] event_time_ms;
    logic        bus_idle;
  } in_t;

  typedef struct packed {
    logic        query_issue;
    logic [7:0]  query_servo_id;
    logic [15:0] position_slot0;
    logic [15:0] age_slot0;
    logic [15:0] count_slot0;
    logic [15:0] position_slot1;
    logic [15:0] age_slot1;
    logic [15:0] count_slot1;
    logic [1:0]  fresh_mask;
    logic [31:0] busy_misses;
  } out_t;

endpackage

/* design/servo_feedback_poll_tracker_core.sv */
// Position-feedback tracker and query scheduler for two bus servos.
// Input channel (in_valid_i / in_stall_o / in_data_i): one service tick per
// beat: time, commanded ids, poll enable, latest driver event, bus-idle flag.
// Output channel (out_valid_o / out_stall_i / out_data_o): exactly one result
// per tick, in order: query decision plus a snapshot of both slots.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i):
// index 0 sets the query phase (low 4 bits), index 1 the stale limit; other
// indexes are ignored. Always ready; write only while the block is empty.
// Path: a tick passes the divider registers item0_q, item1_q and item2_q,
// then the result register. Throughput: one tick per cycle while out_stall_i
// is low. A reciprocal multiply over two stages splits now_ms into frame
// start and phase; slot state and the result register load in the same cycle.
// Reset clears the slots, frame and miss state and loads the default config;
// the first tick after reset adopts the event sequence number, taking no event.
// A stalled result holds; the internal stages keep filling until full, and
// only then does in_stall_o rise.
module servo_feedback_poll_tracker_core #(
  parameter int unsigned FramePeriod = svfpt_pkg::FramePeriodDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  svfpt_pkg::in_t                    in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output svfpt_pkg::out_t                   out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [svfpt_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [svfpt_pkg::CfgDataW-1:0]    cfg_data_i
);

  logic [3:0]  qphase_q;
  logic [15:0] stale_q;

  logic                           dv_valid, dv_ready;
  svfpt_pkg::in_t                 dv_item;
  logic [$clog2(FramePeriod)-1:0] dv_phase;
  logic [31:0]                    dv_fs;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qphase_q <= svfpt_pkg::QueryPhaseRst;
      stale_q  <= svfpt_pkg::StaleLimitRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        svfpt_pkg::CfgQueryPhase: qphase_q <= cfg_data_i[3:0];
        svfpt_pkg::CfgStaleLimit: stale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  svfpt_frame_div #(
    .FrameP (FramePeriod)
  ) u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_valid_i),
    .stall_o       (in_stall_o),
    .item_i        (in_data_i),
    .valid_o       (dv_valid),
    .ready_i       (dv_ready),
    .item_o        (dv_item),
    .phase_o       (dv_phase),
    .frame_start_o (dv_fs)
  );

  svfpt_track #(
    .FrameP (FramePeriod)
  ) u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (dv_valid),
    .ready_o       (dv_ready),
    .item_i        (dv_item),
    .phase_i       (dv_phase),
    .frame_start_i (dv_fs),
    .qphase_i      (qphase_q),
    .stale_i       (stale_q),
    .valid_o       (out_valid_o),
    .stall_i       (out_stall_i),
    .res_o         (out_data_o)
  );

endmodule

/* design/svfpt_frame_div.sv */
`include "assert_macros.svh"

// Splits now_ms into frame start and phase: reciprocal multiply, then one
// correction step. Three register stages, each advancing independently.
module svfpt_frame_div #(
  parameter int unsigned FrameP = svfpt_pkg::FramePeriodDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  svfpt_pkg::in_t            item_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output svfpt_pkg::in_t            item_o,
  output logic [$clog2(FrameP)-1:0] phase_o,
  output logic [31:0]               frame_start_o
);

  localparam int unsigned PhW   = $clog2(FrameP);
  localparam int unsigned Shift = 32 + PhW;
  // floor(2^Shift / P) < 2^33; quotient estimate is exact or one low
  localparam logic [32:0] Recip = 33'(((65'd1) << Shift) / FrameP);
  localparam logic [31:0] PerW  = 32'(FrameP);

  logic           valid0_q, valid1_q, valid2_q;
  logic           rdy0, rdy1, rdy2;
  svfpt_pkg::in_t item0_q, item1_q, item2_q;
  logic [64:0]    prod;
  logic [31:0]    quot1_d, quot1_q;
  logic [31:0]    qp, r_raw, fs2_d, fs2_q;
  logic           corr;
  logic [PhW-1:0] phase2_d, phase2_q;

  assign rdy2    = !valid2_q || ready_i;
  assign rdy1    = !valid1_q || rdy2;
  assign rdy0    = !valid0_q || rdy1;
  assign stall_o = !rdy0;

  assign prod    = {33'b0, item0_q.now_ms} * {32'b0, Recip};
  assign quot1_d = 32'(prod >> Shift);

  always_comb begin
    qp       = quot1_q * PerW;
    r_raw    = item1_q.now_ms - qp;
    corr     = r_raw >= PerW;
    phase2_d = corr ? PhW'(r_raw - PerW) : PhW'(r_raw);
    fs2_d    = corr ? qp + PerW : qp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      if (rdy0) valid0_q <= valid_i;
      if (rdy1) valid1_q <= valid0_q;
      if (rdy2) valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && valid_i) begin
      item0_q <= item_i;
    end
    if (rdy1 && valid0_q) begin
      item1_q <= item0_q;
      quot1_q <= quot1_d;
    end
    if (rdy2 && valid1_q) begin
      item2_q  <= item1_q;
      phase2_q <= phase2_d;
      fs2_q    <= fs2_d;
    end
  end

  assign valid_o       = valid2_q;
  assign item_o        = item2_q;
  assign phase_o       = phase2_q;
  assign frame_start_o = fs2_q;

  `SVFPT_ASSERT_IMPL(a_recip_err, valid1_q, r_raw < 32'(2 * FrameP),
    "reciprocal estimate off by more than one")
  `SVFPT_ASSERT_IMPL(a_split_sum, valid2_q,
    fs2_q + 32'(phase2_q) == item2_q.now_ms, "frame start plus phase differs from time")
  `SVFPT_ASSERT_IMPL(a_phase_rng, valid2_q, 32'(phase2_q) < PerW,
    "phase outside frame")

endmodule

/* design/svfpt_track.sv */
`include "assert_macros.svh"

// Slot tracking, event capture, query scheduling and the result register.
module svfpt_track #(
  parameter int unsigned FrameP = svfpt_pkg::FramePeriodDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  svfpt_pkg::in_t            item_i,
  input  logic [$clog2(FrameP)-1:0] phase_i,
  input  logic [31:0]               frame_start_i,
  input  logic [3:0]                qphase_i,
  input  logic [15:0]               stale_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output svfpt_pkg::out_t           res_o
);

  localparam int unsigned Sl = svfpt_pkg::Slots;

  logic            out_valid_q;
  svfpt_pkg::out_t res_d, res_q;
  logic            load;

  logic [7:0]  slot_id_q [Sl];
  logic [15:0] cnt_q     [Sl];
  logic [15:0] cnt_d     [Sl];
  logic [31:0] stime_q   [Sl];
  logic [31:0] stime_d   [Sl];
  logic [15:0] spos_q    [Sl];
  logic [15:0] spos_d    [Sl];
  logic [7:0]  ids       [Sl];
  logic [31:0] age       [Sl];
  logic [15:0] pos_r     [Sl];
  logic [15:0] age_r     [Sl];
  logic [15:0] cnt_r     [Sl];
  logic [Sl-1:0] have_q, have_d, ok_q, ok_d, chg, hit, fresh;
  logic          matched, new_evt, take;

  logic        started_q;
  logic [31:0] seen_q, seen_eff;
  logic [31:0] lfs_q, lfs_cur, lfs_d;
  logic [31:0] miss_q, miss_d;
  logic        nqs_q, nqs_d;
  logic        issue, miss_inc;
  logic [7:0]  qid;

  assign ready_o = !out_valid_q || !stall_i;
  assign load    = valid_i && ready_o;
  assign ids[0]  = item_i.servo_id_0;
  assign ids[1]  = item_i.servo_id_1;

  always_comb begin
    seen_eff = started_q ? seen_q : item_i.event_sequence;
    new_evt  = item_i.event_sequence != seen_eff;
    take     = 1'b0;
    matched  = 1'b0;
    hit      = '0;
    // first slot whose (new) id matches takes the event
    for (int s = 0; s < Sl; s++) begin
      chg[s] = slot_id_q[s] != ids[s];
      if (new_evt && !matched && ids[s] == item_i.event_servo_id) begin
        hit[s]  = 1'b1;
        matched = 1'b1;
      end
    end
    for (int s = 0; s < Sl; s++) begin
      take      = hit[s] && item_i.event_ok;
      have_d[s] = (have_q[s] && !chg[s]) || take;
      ok_d[s]   = hit[s] ? item_i.event_ok : (ok_q[s] && !chg[s]);
      cnt_d[s]  = (chg[s] ? 16'd0 : cnt_q[s]) + {15'd0, take};
      stime_d[s] = take ? item_i.event_time_ms : stime_q[s];
      spos_d[s]  = take ? item_i.event_position_us : spos_q[s];
      age[s]     = item_i.now_ms - stime_d[s];
      pos_r[s]   = have_d[s] ? spos_d[s] : 16'd0;
      cnt_r[s]   = have_d[s] ? cnt_d[s] : 16'd0;
      age_r[s]   = !have_d[s] ? 16'd0 :
                   (age[s] > {16'd0, svfpt_pkg::AgeCap}) ? svfpt_pkg::AgeCap : age[s][15:0];
      fresh[s]   = have_d[s] && ok_d[s] && (age[s] <= {16'd0, stale_i});
    end
  end

  always_comb begin
    lfs_cur  = started_q ? lfs_q : svfpt_pkg::NoFrame;
    lfs_d    = lfs_cur;
    nqs_d    = nqs_q;
    issue    = 1'b0;
    miss_inc = 1'b0;
    qid      = 8'd0;
    if (!item_i.poll_en) begin
      lfs_d = frame_start_i;
    end else if (32'(phase_i) >= {28'd0, qphase_i} && lfs_cur != frame_start_i) begin
      lfs_d = frame_start_i;
      nqs_d = !nqs_q;
      if (!item_i.bus_idle) begin
        miss_inc = 1'b1;
      end else begin
        issue = 1'b1;
        qid   = ids[nqs_q];
      end
    end
    miss_d = miss_q + {31'd0, miss_inc};

    res_d.query_issue    = issue;
    res_d.query_servo_id = qid;
    res_d.position_slot0 = pos_r[0];
    res_d.age_slot0      = age_r[0];
    res_d.count_slot0    = cnt_r[0];
    res_d.position_slot1 = pos_r[1];
    res_d.age_slot1      = age_r[1];
    res_d.count_slot1    = cnt_r[1];
    res_d.fresh_mask     = fresh;
    res_d.busy_misses    = miss_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
      seen_q      <= '0;
      lfs_q       <= svfpt_pkg::NoFrame;
      miss_q      <= '0;
      nqs_q       <= 1'b0;
      have_q      <= '0;
      ok_q        <= '0;
      for (int s = 0; s < Sl; s++) begin
        slot_id_q[s] <= '0;
        cnt_q[s]     <= '0;
      end
    end else begin
      out_valid_q <= load || (out_valid_q && stall_i);
      if (load) begin
        started_q <= 1'b1;
        // after any tick the seen sequence equals the tick's sequence
        seen_q    <= item_i.event_sequence;
        lfs_q     <= lfs_d;
        miss_q    <= miss_d;
        nqs_q     <= nqs_d;
        have_q    <= have_d;
        ok_q      <= ok_d;
        for (int s = 0; s < Sl; s++) begin
          slot_id_q[s] <= ids[s];
          cnt_q[s]     <= cnt_d[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
      for (int s = 0; s < Sl; s++) begin
        stime_q[s] <= stime_d[s];
        spos_q[s]  <= spos_d[s];
      end
    end
  end

  assign valid_o = out_valid_q;
  assign res_o   = res_q;

  `SVFPT_ASSERT_NEXT(a_miss_no_issue, load && miss_inc,
    !res_q.query_issue && res_q.busy_misses == $past(miss_q) + 32'd1,
    "busy miss must count once and issue nothing")
  `SVFPT_ASSERT_IMPL(a_fresh0_age, out_valid_q && res_q.fresh_mask[0],
    res_q.age_slot0 <= stale_i, "slot zero fresh beyond stale limit")
  `SVFPT_ASSERT_IMPL(a_fresh1_age, out_valid_q && res_q.fresh_mask[1],
    res_q.age_slot1 <= stale_i, "slot one fresh beyond stale limit")

endmodule
